FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by ray_box_hit_distance.sv
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, checked during reset too
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rbhd_pkg.sv
// ---------------------------------------------------------------------------
// rbhd_pkg
// shared types and constants for the ray versus box slab test
// ---------------------------------------------------------------------------
`default_nettype none

package rbhd_pkg;

   // fixed point word layout
   localparam int WORD_W            = 32;
   localparam int DIFF_W            = WORD_W + 1;
   localparam int PROD_W            = DIFF_W + WORD_W;
   localparam int DIST_W            = 31;
   localparam int FRAC_BITS_DEFAULT = 16;

   // input word: box corners, ray origin, inverse direction
   typedef struct packed {
      logic signed [WORD_W-1:0] box_min_x;
      logic signed [WORD_W-1:0] box_min_y;
      logic signed [WORD_W-1:0] box_min_z;
      logic signed [WORD_W-1:0] box_max_x;
      logic signed [WORD_W-1:0] box_max_y;
      logic signed [WORD_W-1:0] box_max_z;
      logic signed [WORD_W-1:0] ray_origin_x;
      logic signed [WORD_W-1:0] ray_origin_y;
      logic signed [WORD_W-1:0] ray_origin_z;
      logic signed [WORD_W-1:0] inv_dir_x;
      logic signed [WORD_W-1:0] inv_dir_y;
      logic signed [WORD_W-1:0] inv_dir_z;
   } req_word_type;

   // result word
   typedef struct packed {
      logic              is_hit;
      logic [DIST_W-1:0] hit_distance;
   } rsp_word_type;

   // per-stage load enables from the pipeline control
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

endpackage

`default_nettype wire

FILE: rtl/rbhd_slab_unit.sv
// ---------------------------------------------------------------------------
// rbhd_slab_unit
// one axis: entry/exit distance, three stages (subtract, multiply, rescale)
// ---------------------------------------------------------------------------
`default_nettype none

module rbhd_slab_unit #(
   parameter int FRAC_BITS = rbhd_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire rbhd_pkg::stage_en_type            stage_en,
   input  wire logic signed [rbhd_pkg::WORD_W-1:0] bound_min,
   input  wire logic signed [rbhd_pkg::WORD_W-1:0] bound_max,
   input  wire logic signed [rbhd_pkg::WORD_W-1:0] origin,
   input  wire logic signed [rbhd_pkg::WORD_W-1:0] inv_dir,
   output logic signed [rbhd_pkg::WORD_W-1:0]      dist_lo,
   output logic signed [rbhd_pkg::WORD_W-1:0]      dist_hi
);
   import rbhd_pkg::*;

   localparam int Q_W = PROD_W - FRAC_BITS;

   logic signed [DIFF_W-1:0] diff_lo_in, diff_hi_in, diff_lo_ff, diff_hi_ff;
   logic signed [WORD_W-1:0] inv_ff;
   logic signed [PROD_W-1:0] prod_lo_in, prod_hi_in, prod_lo_ff, prod_hi_ff;
   logic signed [WORD_W-1:0] sat_lo_in, sat_hi_in, sat_lo_ff, sat_hi_ff;
   logic signed [WORD_W-1:0] near_bound, far_bound;

   // stage 1: pick near/far bound by inverse sign, exact 33-bit difference
   always_comb begin
      near_bound = inv_dir[WORD_W-1] ? bound_max : bound_min;
      far_bound  = inv_dir[WORD_W-1] ? bound_min : bound_max;
      diff_lo_in = $signed({near_bound[WORD_W-1], near_bound})
                 - $signed({origin[WORD_W-1], origin});
      diff_hi_in = $signed({far_bound[WORD_W-1], far_bound})
                 - $signed({origin[WORD_W-1], origin});
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         diff_lo_ff <= diff_lo_in;
         diff_hi_ff <= diff_hi_in;
         inv_ff     <= inv_dir;
      end
   end

   // stage 2: exact signed products
   always_comb begin
      prod_lo_in = PROD_W'(diff_lo_ff) * PROD_W'(inv_ff);
      prod_hi_in = PROD_W'(diff_hi_ff) * PROD_W'(inv_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
      end
   end

   // floor rescale then saturate to the signed word range
   function automatic logic signed [WORD_W-1:0] rescale_sat(
      input logic signed [PROD_W-1:0] prod
   );
      logic signed [Q_W-1:0] q;
      logic                  in_range;
      q        = Q_W'(prod >>> FRAC_BITS);
      in_range = (&q[Q_W-1:WORD_W-1]) | ~(|q[Q_W-1:WORD_W-1]);
      if (in_range) begin
         rescale_sat = q[WORD_W-1:0];
      end else if (q[Q_W-1]) begin
         rescale_sat = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         rescale_sat = {1'b0, {(WORD_W-1){1'b1}}};
      end
   endfunction

   // stage 3: rescaled distances
   always_comb begin
      sat_lo_in = rescale_sat(prod_lo_ff);
      sat_hi_in = rescale_sat(prod_hi_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         sat_lo_ff <= sat_lo_in;
         sat_hi_ff <= sat_hi_in;
      end
   end

   assign dist_lo = sat_lo_ff;
   assign dist_hi = sat_hi_ff;

endmodule

`default_nettype wire

FILE: rtl/rbhd_span_merge.sv
// ---------------------------------------------------------------------------
// rbhd_span_merge
// intersects x, y and z spans over two stages and picks the hit distance
// ---------------------------------------------------------------------------
`default_nettype none

module rbhd_span_merge (
   input  wire logic                               clock,
   input  wire rbhd_pkg::stage_en_type             stage_en,
   input  wire logic signed [rbhd_pkg::WORD_W-1:0] x_lo,
   input  wire logic signed [rbhd_pkg::WORD_W-1:0] x_hi,
   input  wire logic signed [rbhd_pkg::WORD_W-1:0] y_lo,
   input  wire logic signed [rbhd_pkg::WORD_W-1:0] y_hi,
   input  wire logic signed [rbhd_pkg::WORD_W-1:0] z_lo,
   input  wire logic signed [rbhd_pkg::WORD_W-1:0] z_hi,
   output rbhd_pkg::rsp_word_type                  rsp_data
);
   import rbhd_pkg::*;

   logic                     hit4_in, hit4_ff;
   logic signed [WORD_W-1:0] tmin4_in, tmax4_in, tmin4_ff, tmax4_ff;
   logic signed [WORD_W-1:0] zlo4_ff, zhi4_ff;
   logic signed [WORD_W-1:0] tmin5, tmax5, pick5;
   logic                     hit5;
   rsp_word_type             rsp_in, rsp_ff;

   // stage 4: x against y
   always_comb begin
      hit4_in  = !((x_lo > y_hi) || (y_lo > x_hi));
      tmin4_in = (y_lo > x_lo) ? y_lo : x_lo;
      tmax4_in = (y_hi < x_hi) ? y_hi : x_hi;
   end

   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         hit4_ff  <= hit4_in;
         tmin4_ff <= tmin4_in;
         tmax4_ff <= tmax4_in;
         zlo4_ff  <= z_lo;
         zhi4_ff  <= z_hi;
      end
   end

   // stage 5: merge z, then entry distance or exit when entry is behind
   always_comb begin
      hit5  = hit4_ff && !((tmin4_ff > zhi4_ff) || (zlo4_ff > tmax4_ff));
      tmin5 = (zlo4_ff > tmin4_ff) ? zlo4_ff : tmin4_ff;
      tmax5 = (zhi4_ff < tmax4_ff) ? zhi4_ff : tmax4_ff;
      pick5 = tmin5[WORD_W-1] ? tmax5 : tmin5;
      if (hit5 && !pick5[WORD_W-1]) begin
         rsp_in.is_hit       = 1'b1;
         rsp_in.hit_distance = pick5[DIST_W-1:0];
      end else begin
         rsp_in.is_hit       = 1'b0;
         rsp_in.hit_distance = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s5) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/ray_box_hit_distance.sv
// an accepted req word is registered in stages s1 to s5 in turn, and
// rsp_valid rises once it reaches s5; no word is lost or repeated
// throughput: one word per cycle with rsp_ready high, five-stage pipeline
// (subtract, 33x32 multiply, rescale, x/y merge, z merge and select)
// a stalled rsp holds each full stage that has only full stages after it
// reset: synchronous, active high, clears all stage valid bits
// ---------------------------------------------------------------------------
// ray_box_hit_distance
// slab-method ray versus axis-aligned box test, signed fixed point
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ray_box_hit_distance #(
   parameter int FRAC_BITS = rbhd_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire rbhd_pkg::req_word_type req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rbhd_pkg::rsp_word_type      rsp_word
);
   import rbhd_pkg::*;

   localparam int STAGES = 5;

   logic [STAGES-1:0]        valid_in, valid_ff;
   logic [STAGES-1:0]        stage_ready;
   logic [STAGES-1:0]        stage_src;
   stage_en_type             stage_en;
   logic signed [WORD_W-1:0] x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;

   // ready chain: a stage loads when empty or when its content moves on
   always_comb begin
      stage_ready[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      stage_src = {valid_ff[STAGES-2:0], req_valid};
      for (int k = 0; k < STAGES; k++) begin
         valid_in[k] = stage_ready[k] ? stage_src[k] : valid_ff[k];
      end
      stage_en.s1 = stage_ready[0];
      stage_en.s2 = stage_ready[1];
      stage_en.s3 = stage_ready[2];
      stage_en.s4 = stage_ready[3];
      stage_en.s5 = stage_ready[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_ready[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // per-axis distance units
   rbhd_slab_unit #(.FRAC_BITS(FRAC_BITS)) u_slab_x (
      .clock     (clock),
      .stage_en  (stage_en),
      .bound_min (req_word.box_min_x),
      .bound_max (req_word.box_max_x),
      .origin    (req_word.ray_origin_x),
      .inv_dir   (req_word.inv_dir_x),
      .dist_lo   (x_lo),
      .dist_hi   (x_hi)
   );

   rbhd_slab_unit #(.FRAC_BITS(FRAC_BITS)) u_slab_y (
      .clock     (clock),
      .stage_en  (stage_en),
      .bound_min (req_word.box_min_y),
      .bound_max (req_word.box_max_y),
      .origin    (req_word.ray_origin_y),
      .inv_dir   (req_word.inv_dir_y),
      .dist_lo   (y_lo),
      .dist_hi   (y_hi)
   );

   rbhd_slab_unit #(.FRAC_BITS(FRAC_BITS)) u_slab_z (
      .clock     (clock),
      .stage_en  (stage_en),
      .bound_min (req_word.box_min_z),
      .bound_max (req_word.box_max_z),
      .origin    (req_word.ray_origin_z),
      .inv_dir   (req_word.inv_dir_z),
      .dist_lo   (z_lo),
      .dist_hi   (z_hi)
   );

   // span intersection and hit select
   rbhd_span_merge u_merge (
      .clock    (clock),
      .stage_en (stage_en),
      .x_lo     (x_lo),
      .x_hi     (x_hi),
      .y_lo     (y_lo),
      .y_hi     (y_hi),
      .z_lo     (z_lo),
      .z_hi     (z_hi),
      .rsp_data (rsp_word)
   );

   // checks
   `ASSERT_CLK_RST(a_miss_zero, clock, reset, rsp_valid && !rsp_word.is_hit |-> rsp_word.hit_distance == '0, "miss with nonzero distance")
   `ASSERT_CLK_RST(a_accept_fills, clock, reset, req_valid && req_ready |=> valid_ff[0], "accepted word not in first stage")
   `ASSERT_CLK_RST(a_full_blocks, clock, reset, (&valid_ff) && !rsp_ready |-> !req_ready, "full stalled pipe still ready")
   `ASSERT_CLK(a_reset_empty, clock, reset |=> valid_ff == '0, "pipe not empty after reset")

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench for ray_box_hit_distance
// drives ray and box words through the valid/ready input, predicts the hit
// flag and distance of each word with a slab-test model of its own, and
// checks every result word in order under random idling and back-pressure
// ---------------------------------------------------------------------------

module testbench;
   import rbhd_pkg::*;

   localparam int     FRAC           = FRAC_BITS_DEFAULT;
   localparam int     ONE            = 1 << FRAC;
   localparam int     PIPE_LATENCY   = 5;
   localparam int     HOLD_CYCLES    = 200;
   localparam int     WATCHDOG_LIMIT = 2000;
   localparam longint DIST_MAX       = 64'sd2147483647;
   localparam longint DIST_MIN       = -64'sd2147483648;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   rsp_word_type pending_hits[$];
   int           error_count    = 0;
   int           result_count   = 0;
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   logic         hold_start     = 1'b0;
   int           hold_left      = 0;
   int           quiet_cycles   = 0;

   ray_box_hit_distance u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // hit prediction
   // ------------------------------------------------------------------

   // (bound - origin) * inv, floor rescale, clamp to 32-bit signed
   function automatic longint slab_edge(input logic signed [31:0] bound,
                                        input logic signed [31:0] origin,
                                        input logic signed [31:0] inv);
      longint prod;
      longint q;
      prod = (longint'(bound) - longint'(origin)) * longint'(inv);
      q = prod >>> FRAC;
      if (q > DIST_MAX) q = DIST_MAX;
      if (q < DIST_MIN) q = DIST_MIN;
      return q;
   endfunction

   function automatic rsp_word_type predict_hit(input req_word_type w);
      logic signed [31:0] lo_b[3];
      logic signed [31:0] hi_b[3];
      logic signed [31:0] org[3];
      logic signed [31:0] inv[3];
      longint             near_t[3];
      longint             far_t[3];
      longint             t_min;
      longint             t_max;
      longint             t;
      logic               hit;
      rsp_word_type       r;
      lo_b = '{w.box_min_x, w.box_min_y, w.box_min_z};
      hi_b = '{w.box_max_x, w.box_max_y, w.box_max_z};
      org  = '{w.ray_origin_x, w.ray_origin_y, w.ray_origin_z};
      inv  = '{w.inv_dir_x, w.inv_dir_y, w.inv_dir_z};
      // per-axis span, swapped when the inverse is negative
      for (int ax = 0; ax < 3; ax++) begin
         if (inv[ax] >= 0) begin
            near_t[ax] = slab_edge(lo_b[ax], org[ax], inv[ax]);
            far_t[ax]  = slab_edge(hi_b[ax], org[ax], inv[ax]);
         end else begin
            near_t[ax] = slab_edge(hi_b[ax], org[ax], inv[ax]);
            far_t[ax]  = slab_edge(lo_b[ax], org[ax], inv[ax]);
         end
      end
      // intersect x, then y, then z; touching spans still hit
      t_min = near_t[0];
      t_max = far_t[0];
      hit   = 1'b1;
      for (int ax = 1; ax < 3; ax++) begin
         if (hit) begin
            if (t_min > far_t[ax] || near_t[ax] > t_max) begin
               hit = 1'b0;
            end else begin
               if (near_t[ax] > t_min) t_min = near_t[ax];
               if (far_t[ax] < t_max) t_max = far_t[ax];
            end
         end
      end
      // entry distance, or exit when the origin is inside
      t = t_min;
      if (hit && t < 0) begin
         t = t_max;
         if (t < 0) hit = 1'b0;
      end
      r.is_hit       = hit;
      r.hit_distance = hit ? t[DIST_W-1:0] : '0;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // word generators
   // ------------------------------------------------------------------

   function automatic req_word_type make_word(
         input int bx0, input int by0, input int bz0,
         input int bx1, input int by1, input int bz1,
         input int ox,  input int oy,  input int oz,
         input int ix,  input int iy,  input int iz);
      return '{bx0, by0, bz0, bx1, by1, bz1, ox, oy, oz, ix, iy, iz};
   endfunction

   // ray aimed at a point inside a random box, mostly from in front
   function automatic req_word_type aimed_ray();
      int     lo_b[3];
      int     hi_b[3];
      int     org[3];
      int     inv[3];
      int     span;
      int     point;
      int     swap_tmp;
      longint t;
      longint dir;
      t = longint'($urandom_range(0, 32 << FRAC));
      if ($urandom_range(9) == 0) t = t - (longint'(40) << FRAC);
      for (int ax = 0; ax < 3; ax++) begin
         lo_b[ax] = int'($urandom_range(0, 128 << FRAC)) - (64 << FRAC);
         span     = ($urandom_range(19) == 0) ? 0 : int'($urandom_range(1, 16 << FRAC));
         hi_b[ax] = lo_b[ax] + span;
         point    = lo_b[ax] + int'($urandom_range(0, span));
         // inverted box now and then
         if ($urandom_range(19) == 0) begin
            swap_tmp = lo_b[ax];
            lo_b[ax] = hi_b[ax];
            hi_b[ax] = swap_tmp;
         end
         if ($urandom_range(19) == 0) begin
            inv[ax] = 0;
            org[ax] = point;
         end else begin
            inv[ax] = int'($urandom_range(1 << (FRAC - 3), 1 << (FRAC + 3)));
            if ($urandom_range(1)) inv[ax] = -inv[ax];
            dir     = (longint'(1) << (2 * FRAC)) / inv[ax];
            org[ax] = point - int'((t * dir) >>> FRAC);
         end
      end
      return make_word(lo_b[0], lo_b[1], lo_b[2], hi_b[0], hi_b[1], hi_b[2],
                       org[0], org[1], org[2], inv[0], inv[1], inv[2]);
   endfunction

   // aimed rays mostly, plus small-range and full-range noise
   function automatic req_word_type random_ray();
      logic [11:0][31:0] flat;
      int                roll;
      roll = $urandom_range(99);
      if (roll < 70) return aimed_ray();
      for (int i = 0; i < 12; i++) begin
         if (roll < 85) flat[i] = int'($urandom_range(0, 32 << FRAC)) - (16 << FRAC);
         else flat[i] = $urandom;
      end
      return req_word_type'(flat);
   endfunction

   // ------------------------------------------------------------------
   // shared driving tasks
   // ------------------------------------------------------------------

   // offer one word, with a random gap first, and wait for its accept
   task automatic send_word(input req_word_type w);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   // step past the accepting edge first so the last accepted word is already queued
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_hits.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input longint want,
                                  input longint got);
      $display("mismatch on result %0d: %s expected %0h got %0h",
               result_count, what, want, got);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // receiver: random stalls, plus a long hold-off on request
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_start) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // predict on accept, compare on each result word
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rsp_word_type want;
      if (!reset) begin
         if (req_valid && req_ready) pending_hits.push_back(predict_hit(req_word));
         if (rsp_valid && rsp_ready) begin
            if (pending_hits.size() == 0) begin
               report_mismatch("unexpected word", 0, longint'(rsp_word));
            end else begin
               want = pending_hits.pop_front();
               if (rsp_word.is_hit !== want.is_hit)
                  report_mismatch("is_hit", want.is_hit, rsp_word.is_hit);
               if (rsp_word.hit_distance !== want.hit_distance)
                  report_mismatch("hit_distance", want.hit_distance, rsp_word.hit_distance);
            end
            result_count++;
         end
      end
   end

   // watchdog on cycles where no word moves
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   task automatic test_directed_cases();
      send_idle_pct  <= 0;
      recv_stall_pct <= 0;
      // plain hit in front, entry at 1
      send_word(make_word(ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 0, 0, 0, ONE, ONE, ONE));
      // origin inside the box, exit reported
      send_word(make_word(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE));
      // box behind the origin
      send_word(make_word(-3*ONE, -3*ONE, -3*ONE, -2*ONE, -2*ONE, -2*ONE,
                          0, 0, 0, ONE, ONE, ONE));
      // negative inverse, spans swapped
      send_word(make_word(ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE,
                          3*ONE, 3*ONE, 3*ONE, -ONE, -ONE, -ONE));
      // disjoint on y, then on z
      send_word(make_word(ONE, 5*ONE, ONE, 2*ONE, 6*ONE, 2*ONE, 0, 0, 0, ONE, ONE, ONE));
      send_word(make_word(ONE, ONE, 5*ONE, 2*ONE, 2*ONE, 6*ONE, 0, 0, 0, ONE, ONE, ONE));
      // spans that just touch
      send_word(make_word(ONE, 2*ONE, ONE, 2*ONE, 3*ONE, 3*ONE, 0, 0, 0, ONE, ONE, ONE));
      // zero inverse on one axis and on all axes
      send_word(make_word(ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 0, 0, 0, 0, ONE, ONE));
      send_word(make_word(ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 0, 0, 0, 0, 0, 0));
      // inverted box on x
      send_word(make_word(2*ONE, 0, 0, ONE, 3*ONE, 3*ONE, 0, 0, 0, ONE, ONE, ONE));
      // saturated inverse, direction zero, origin inside the slab
      send_word(make_word(-ONE, ONE, -ONE, ONE, 2*ONE, ONE,
                          0, 0, 0, 32'h7fffffff, ONE, 32'h7fffffff));
      // field extremes and bit patterns
      send_word('0);
      send_word('1);
      send_word({12{32'h7fffffff}});
      send_word({12{32'h80000000}});
      send_word({12{32'h55555555}});
      send_word({12{32'haaaaaaaa}});
      // products that clamp high and low
      send_word(make_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      send_word(make_word(32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h80000000, 32'h80000000, 32'h80000000));
      send_word(make_word(32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          0, 0, 0, 32'h80000000, 32'h7fffffff, 32'h80000000));
      wait_drained();
   endtask

   task automatic test_random_rays(input int idle_pct, input int stall_pct,
                                   input int count);
      send_idle_pct  <= idle_pct;
      recv_stall_pct <= stall_pct;
      for (int i = 0; i < count; i++) send_word(random_ray());
      wait_drained();
   endtask

   // receiver holds off while words keep coming, so the pipe fills
   task automatic test_backpressure();
      send_idle_pct  <= 0;
      recv_stall_pct <= 0;
      hold_start     <= 1'b1;
      @(posedge clock);
      hold_start     <= 1'b0;
      for (int i = 0; i < 50; i++) send_word(random_ray());
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_rays(0, 0, 320);
      test_random_rays(85, 0, 320);
      test_random_rays(0, 85, 320);
      test_random_rays(30, 30, 320);
      test_backpressure();
      wait_drained();
      repeat (4 * PIPE_LATENCY) @(posedge clock);
      if (error_count == 0 && pending_hits.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rbhd_pkg.sv
rtl/rbhd_slab_unit.sv
rtl/rbhd_span_merge.sv
rtl/ray_box_hit_distance.sv
bench/testbench.sv
